@@ src/pbfs_pkg.sv @@
// shared constants, codes and types of the packed 3-bit field store
package pbfs_pkg;

    localparam int STORE_BYTES = 64;
    localparam int ENTRY_BITS  = 3;
    localparam int BYTE_AW     = $clog2(STORE_BYTES);
    localparam int BANK_DEPTH  = STORE_BYTES / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    // bit address space of the configuration: reserved_bytes (7 bits) times 8
    localparam int BIT_W       = 10;
    localparam int WIN_W       = 16;
    localparam int SH_W        = 4;

    localparam logic [ENTRY_BITS-1:0] ENTRY_MASK = '1;
    localparam logic [7:0]            OOR_PIECE_RESET = 8'd7;

    typedef enum logic [1:0] {
        OP_READ_ENTRY  = 2'd0,
        OP_WRITE_ENTRY = 2'd1,
        OP_CLEAR_PAD   = 2'd2,
        OP_READ_BYTE   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CFG_TOTAL_POSITIONS = 2'd0,
        CFG_RESERVED_BYTES  = 2'd1,
        CFG_OOR_PIECE       = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_MOD  = 1'b1
    } t_state;

endpackage

@@ src/packed_3bit_field_store.sv @@
// top level of the packed 3-bit field store: control, address math and merge
//
//  channel    | signals                                              | timing
//  -----------+------------------------------------------------------+-------------------
//  command    | start, busy, i_operation, i_position, i_value,       | taken at start & !busy
//             | i_byte_index                                         |
//  result     | o_strobe, o_piece, o_byte_data, o_out_of_range       | one cycle, no stall
//  config     | i_cfg_we, i_cfg_index, i_cfg_data                    | taken at i_cfg_we
//
// the accept cycle of a transaction issues reads to the even and odd byte banks, the next
// cycle merges and writes back while busy holds off new commands; the result strobes in
// the cycle after, while the next command may already be taken.
// i_rst_n is synchronous; the store reads as zero right after reset through per-byte
// valid flags, so no clearing pass is needed. the result side cannot stall.
module packed_3bit_field_store
    import pbfs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [1:0] i_operation,
    input  logic [7:0] i_position,
    input  logic [2:0] i_value,
    input  logic [5:0] i_byte_index,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output logic       o_strobe,
    output logic [7:0] o_piece,
    output logic [7:0] o_byte_data,
    output logic       o_out_of_range
);

    // configuration
    logic [7:0] r_total;
    logic [6:0] r_reserved;
    logic [7:0] r_oor_piece;

    // control
    t_state r_state, n_state;
    logic   c_accept;

    // accept-cycle address math
    logic [BIT_W-1:0]   c_need, c_have, c_pad, c_pos3, c_bit;
    logic               c_cfg_ok, c_pos_ok, c_flag;
    logic [BYTE_AW-1:0] c_idx;
    logic [BANK_AW-1:0] c_e_addr, c_o_addr;
    logic [BYTE_AW:0]   c_idx_p1;

    // per-transaction registers
    t_op                r_op;
    logic               r_flag;
    logic [BYTE_AW-1:0] r_idx;
    logic [2:0]         r_off;
    logic [2:0]         r_value;
    logic [BIT_W-4:0]   r_whole;
    logic [2:0]         r_loose;
    logic [BANK_AW-1:0] r_e_addr, r_o_addr;

    // store
    logic [STORE_BYTES-1:0] r_valid, n_valid;
    logic [7:0]             e_rdata, o_rdata;
    logic                   we_e, we_o;
    logic [7:0]             wd_e, wd_o;

    // merge
    logic [BYTE_AW-1:0] idx_p1;
    logic               lo_ok;
    logic [7:0]         hi, lo, hi_raw, lo_raw;
    logic [WIN_W-1:0]   win, win_sh, mask, new_win;
    logic [SH_W-1:0]    sh;
    logic               we_hi, we_lo;
    logic [7:0]         n_hi, n_lo;

    // results
    logic [7:0] r_piece, n_piece;
    logic [7:0] r_byte_data, n_byte_data;
    logic       r_oor, n_oor;
    logic       r_strobe;

    assign c_accept = start && !busy;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_reserved  <= '0;
            r_oor_piece <= OOR_PIECE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TOTAL_POSITIONS: r_total     <= i_cfg_data;
                CFG_RESERVED_BYTES:  r_reserved  <= i_cfg_data[6:0];
                CFG_OOR_PIECE:       r_oor_piece <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        busy    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                busy    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // layout and address of the entry or byte touched
    always_comb begin
        c_need   = {2'b00, r_total} + {1'b0, r_total, 1'b0};
        c_have   = {r_reserved, 3'b000};
        c_cfg_ok = (32'(r_reserved) <= STORE_BYTES) && (c_need <= c_have);
        c_pad    = c_have - c_need;
        c_pos_ok = c_cfg_ok && (i_position < r_total);
        c_pos3   = {2'b00, i_position} + {1'b0, i_position, 1'b0};
        c_bit    = c_pad + c_pos3;
        case (t_op'(i_operation))
            OP_READ_ENTRY, OP_WRITE_ENTRY: begin
                c_idx  = c_bit[3 +: BYTE_AW];
                c_flag = !c_pos_ok;
            end
            OP_CLEAR_PAD: begin
                c_idx  = c_pad[3 +: BYTE_AW];
                c_flag = !c_cfg_ok;
            end
            default: begin
                c_idx  = i_byte_index[BYTE_AW-1:0];
                c_flag = !c_cfg_ok;
            end
        endcase
        // even bank holds the byte at or just after idx, odd bank likewise the other of the two
        c_idx_p1 = {1'b0, c_idx} + 1'b1;
        c_e_addr = c_idx_p1[1 +: BANK_AW];
        c_o_addr = c_idx[1 +: BANK_AW];
    end

    always_ff @(posedge i_clk) begin
        if (c_accept) begin
            r_op     <= t_op'(i_operation);
            r_flag   <= c_flag;
            r_idx    <= c_idx;
            r_off    <= c_bit[2:0];
            r_value  <= i_value;
            r_whole  <= c_pad[BIT_W-1:3];
            r_loose  <= c_pad[2:0];
            r_e_addr <= c_e_addr;
            r_o_addr <= c_o_addr;
        end
    end

    pbfs_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_even_bank (
        .i_clk   (i_clk),
        .i_we    (we_e),
        .i_waddr (r_e_addr),
        .i_wdata (wd_e),
        .i_raddr (c_e_addr),
        .o_rdata (e_rdata)
    );

    pbfs_ram #(
        .WIDTH (8),
        .DEPTH (BANK_DEPTH)
    ) u_odd_bank (
        .i_clk   (i_clk),
        .i_we    (we_o),
        .i_waddr (r_o_addr),
        .i_wdata (wd_o),
        .i_raddr (c_o_addr),
        .o_rdata (o_rdata)
    );

    // merge and write back
    always_comb begin
        idx_p1  = r_idx + 1'b1;
        lo_ok   = (r_idx != {BYTE_AW{1'b1}});
        hi_raw  = r_idx[0] ? o_rdata : e_rdata;
        lo_raw  = r_idx[0] ? e_rdata : o_rdata;
        hi      = r_valid[r_idx] ? hi_raw : 8'h00;
        lo      = (lo_ok && r_valid[idx_p1]) ? lo_raw : 8'h00;
        win     = {hi, lo};
        sh      = SH_W'(WIN_W - ENTRY_BITS) - {1'b0, r_off};
        win_sh  = win >> sh;
        mask    = WIN_W'(ENTRY_MASK) << sh;
        new_win = (win & ~mask) | (WIN_W'(r_value) << sh);

        we_hi       = 1'b0;
        we_lo       = 1'b0;
        n_hi        = new_win[15:8];
        n_lo        = new_win[7:0];
        n_valid     = r_valid;
        n_piece     = 8'h00;
        n_byte_data = 8'h00;
        n_oor       = r_flag;

        if (r_state == S_MOD) begin
            case (r_op)
                OP_READ_ENTRY: begin
                    n_piece = r_flag ? r_oor_piece : {5'b00000, win_sh[ENTRY_BITS-1:0]};
                end
                OP_WRITE_ENTRY: begin
                    we_hi = !r_flag;
                    we_lo = !r_flag && lo_ok;
                end
                OP_CLEAR_PAD: begin
                    if (!r_flag) begin
                        // whole padding bytes drop back to zero through their valid flags
                        for (int i = 0; i < STORE_BYTES; i++) begin
                            if (i < 32'(r_whole)) begin
                                n_valid[i] = 1'b0;
                            end
                        end
                        // partial byte keeps its low bits
                        if (r_loose != 3'd0 && 32'(r_whole) < STORE_BYTES) begin
                            we_hi = 1'b1;
                            n_hi  = hi & (8'hFF >> r_loose);
                        end
                    end
                end
                default: begin
                    n_byte_data = hi;
                end
            endcase
        end

        if (we_hi) begin
            n_valid[r_idx] = 1'b1;
        end
        if (we_lo) begin
            n_valid[idx_p1] = 1'b1;
        end

        we_e = r_idx[0] ? we_lo : we_hi;
        we_o = r_idx[0] ? we_hi : we_lo;
        wd_e = r_idx[0] ? n_lo : n_hi;
        wd_o = r_idx[0] ? n_hi : n_lo;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_valid  <= n_valid;
            r_strobe <= (r_state == S_MOD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_MOD) begin
            r_piece     <= n_piece;
            r_byte_data <= n_byte_data;
            r_oor       <= n_oor;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_piece        = r_piece;
    assign o_byte_data    = r_byte_data;
    assign o_out_of_range = r_oor;

`ifndef NO_ASSERTIONS
    a_mod_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |=> (r_state == S_IDLE))
        else $error("merge stage held longer than one cycle");

    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_accept |-> ##2 o_strobe)
        else $error("result strobe missing two cycles after accept");

    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_MOD))
        else $error("result strobe without a finished transaction");

    a_no_idle_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!we_e && !we_o))
        else $error("bank write outside the merge stage");

    a_read_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_MOD) && (r_op == OP_READ_ENTRY || r_op == OP_READ_BYTE || r_flag))
            |-> (!we_e && !we_o))
        else $error("store modified by a read or a flagged transaction");
`endif

endmodule

@@ src/pbfs_ram.sv @@
// generic single-write, single-read ram with registered read data
module pbfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
